// ----- hdl/dpcm_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpcm_pkg
// shared widths, fixed-point constants and stage types of the depth colormap
// ---------------------------------------------------------------------------
package dpcm_pkg;

	// widths of the sample and of the fixed-point fraction
	localparam int DEPTH_BITS = 16;
	localparam int FRAC_BITS  = 16;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int INV_W      = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIM  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIM   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_RANGE = 2'd2;

	localparam logic [DEPTH_BITS-1:0] NEAR_LIM_RST  = DEPTH_BITS'(300);
	localparam logic [DEPTH_BITS-1:0] FAR_LIM_RST   = DEPTH_BITS'(5000);
	localparam logic [INV_W-1:0]      INV_RANGE_RST = INV_W'(913823);

	// derived widths
	localparam int PROD_W  = DEPTH_BITS + INV_W;
	localparam int NFULL_W = PROD_W - (INV_W - FRAC_BITS);
	localparam int N_W     = FRAC_BITS + 1;
	localparam int H6_W    = FRAC_BITS + 3;
	localparam int SEXT_W  = H6_W - FRAC_BITS;

	// fixed-point constants
	localparam longint unsigned ONE_Q_L = 64'd1 << FRAC_BITS;
	localparam longint unsigned V_Q_L   = 64'd3 << (FRAC_BITS - 2);
	localparam longint unsigned M_Q_L   = 64'd1 << (FRAC_BITS - 2);
	localparam longint unsigned SV_Q_L  = ((64'd6667 << FRAC_BITS) + 64'd5000) / 64'd10000;
	localparam longint unsigned VS_Q_L  = (V_Q_L * SV_Q_L) >> FRAC_BITS;

	localparam logic [FRAC_BITS-1:0] V_Q  = FRAC_BITS'(V_Q_L);
	localparam logic [FRAC_BITS-1:0] M_Q  = FRAC_BITS'(M_Q_L);
	localparam logic [FRAC_BITS-1:0] VS_Q = FRAC_BITS'(VS_Q_L);

	// fixed colours
	localparam logic [31:0] RGBA_BLACK = 32'hFF00_0000;
	localparam logic [31:0] RGBA_GRAY  = 32'hFF80_8080;
	localparam logic [31:0] RGBA_WHITE = 32'hFFFF_FFFF;
	localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

	// sextant codes
	localparam logic [SEXT_W-1:0] SEXT_0 = SEXT_W'(0);
	localparam logic [SEXT_W-1:0] SEXT_1 = SEXT_W'(1);
	localparam logic [SEXT_W-1:0] SEXT_2 = SEXT_W'(2);
	localparam logic [SEXT_W-1:0] SEXT_3 = SEXT_W'(3);
	localparam logic [SEXT_W-1:0] SEXT_4 = SEXT_W'(4);
	localparam logic [SEXT_W-1:0] SEXT_5 = SEXT_W'(5);

	// pixel class decided in the first stage
	typedef enum logic [1:0] {
		CLS_SHADE,
		CLS_BLACK,
		CLS_GRAY,
		CLS_WHITE
	} pix_class_t;

	typedef struct packed {
		pix_class_t            cls;
		logic [DEPTH_BITS-1:0] diff;
	} clsf_t;

	typedef struct packed {
		pix_class_t              cls;
		logic [SEXT_W-1:0]       sextant;
		logic [FRAC_BITS-1:0]    fract;
	} hue_t;

endpackage

// ----- hdl/depth_pixel_colormap.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// depth_pixel_colormap
// turns one depth sample into a packed rgba colour on a hue ramp
// ---------------------------------------------------------------------------
// usage
//  - input channel in_valid/in_ready carries one item: depth and invalid flag
//  - output channel out_valid/out_ready carries one item: rgba, alpha on top
//  - zero or flagged depth gives black, below the near limit gray, above the
//    far limit white; anything else is scaled by inv_range and coloured by
//    six sextants
//  - config port: cfg_we writes cfg_data into register cfg_idx at once
//    (0 near limit, 1 far limit, 2 inv_range, 3 ignored); write only when idle
//  - five register stages: classify, range multiply, saturate and times six,
//    ramp multiply, sextant select and byte pack
//  - an accepted item passes through every stage register in turn before out_valid
//  - throughput is one item per cycle while out_ready stays high; each stage has its
//    own valid bit and loads whenever it is empty or its successor moves on
//  - when out_ready is low the last stage holds its item and earlier stages
//    keep filling up bubbles, so up to five items are held and none is lost
//  - reset clears all valid bits and loads the default register values
// ---------------------------------------------------------------------------
module depth_pixel_colormap (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dpcm_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [dpcm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [dpcm_pkg::DEPTH_BITS-1:0]     depth,
	input  logic                                invalid,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [31:0]                         rgba
);

	// configuration registers
	logic [dpcm_pkg::DEPTH_BITS-1:0] near_lim_q;
	logic [dpcm_pkg::DEPTH_BITS-1:0] far_lim_q;
	logic [dpcm_pkg::INV_W-1:0]      inv_range_q;

	// stage links
	logic            clsf_valid;
	logic            clsf_ready;
	dpcm_pkg::clsf_t clsf_data;
	logic            hue_valid;
	logic            hue_ready;
	dpcm_pkg::hue_t  hue_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_lim_q  <= dpcm_pkg::NEAR_LIM_RST;
			far_lim_q   <= dpcm_pkg::FAR_LIM_RST;
			inv_range_q <= dpcm_pkg::INV_RANGE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				dpcm_pkg::CFG_NEAR_LIM:  near_lim_q  <= cfg_data[dpcm_pkg::DEPTH_BITS-1:0];
				dpcm_pkg::CFG_FAR_LIM:   far_lim_q   <= cfg_data[dpcm_pkg::DEPTH_BITS-1:0];
				dpcm_pkg::CFG_INV_RANGE: inv_range_q <= cfg_data[dpcm_pkg::INV_W-1:0];
				default: begin
					// unknown index: write dropped
				end
			endcase
		end
	end

	// stage 1: special cases and offset from the near limit
	dpcm_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.depth     (depth),
		.invalid   (invalid),
		.near_lim  (near_lim_q),
		.far_lim   (far_lim_q),
		.out_valid (clsf_valid),
		.out_ready (clsf_ready),
		.out_data  (clsf_data)
	);

	// stages 2 and 3: scale to a fraction, clip at one, split into hue parts
	dpcm_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (clsf_valid),
		.in_ready  (clsf_ready),
		.in_data   (clsf_data),
		.inv_range (inv_range_q),
		.out_valid (hue_valid),
		.out_ready (hue_ready),
		.out_data  (hue_data)
	);

	// stages 4 and 5: ramp values, channel select, byte conversion
	dpcm_shade u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hue_valid),
		.in_ready  (hue_ready),
		.in_data   (hue_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rgba      (rgba)
	);

	// every colour leaving the block is opaque
	a_alpha_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rgba[31:24] == dpcm_pkg::ALPHA_OPAQUE)
		else $error("rgba item left with alpha not opaque");

	// a free output drains the whole pipe, so the input must be open
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output is free");

	// stall inside the pipe must not disturb the link into the last stages
	a_hue_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hue_valid && !hue_ready |=> hue_valid && $stable(hue_data))
		else $error("hue item changed while stalled");

	// a stalled classified item stays put until the scaler takes it
	a_link_hold: assert property (@(posedge clk) disable iff (!arst_n)
		clsf_valid && !clsf_ready |=> clsf_valid && $stable(clsf_data))
		else $error("classified item changed while stalled");

endmodule

// ----- hdl/dpcm_classify.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpcm_classify
// first stage: sorts a sample into black, gray, white or shaded
// ---------------------------------------------------------------------------
module dpcm_classify (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [dpcm_pkg::DEPTH_BITS-1:0]     depth,
	input  logic                                invalid,
	input  logic [dpcm_pkg::DEPTH_BITS-1:0]     near_lim,
	input  logic [dpcm_pkg::DEPTH_BITS-1:0]     far_lim,
	output logic                                out_valid,
	input  logic                                out_ready,
	output dpcm_pkg::clsf_t                     out_data
);

	logic            valid_s1;
	dpcm_pkg::clsf_t data_s1;
	dpcm_pkg::clsf_t data_d;
	logic            en;

	assign en       = !valid_s1 || out_ready;
	assign in_ready = en;

	always_comb begin
		data_d.diff = depth - near_lim;
		if (invalid || depth == '0) begin
			data_d.cls = dpcm_pkg::CLS_BLACK;
		end else if (depth < near_lim) begin
			data_d.cls = dpcm_pkg::CLS_GRAY;
		end else if (depth > far_lim) begin
			data_d.cls = dpcm_pkg::CLS_WHITE;
		end else begin
			data_d.cls = dpcm_pkg::CLS_SHADE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			data_s1 <= data_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ----- hdl/dpcm_scale.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpcm_scale
// two stages: range multiply, then saturate and split into sextant and fraction
// ---------------------------------------------------------------------------
module dpcm_scale (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  dpcm_pkg::clsf_t                   in_data,
	input  logic [dpcm_pkg::INV_W-1:0]        inv_range,
	output logic                              out_valid,
	input  logic                              out_ready,
	output dpcm_pkg::hue_t                    out_data
);

	logic                           valid_s2;
	dpcm_pkg::pix_class_t           cls_s2;
	logic [dpcm_pkg::PROD_W-1:0]    prod_s2;
	logic                           valid_s3;
	dpcm_pkg::hue_t                 hue_s3;
	logic                           en2;
	logic                           en3;
	logic [dpcm_pkg::NFULL_W-1:0]   n_full;
	logic [dpcm_pkg::N_W-1:0]       n_sat;
	logic [dpcm_pkg::H6_W-1:0]      h6;

	assign en3      = !valid_s3 || out_ready;
	assign en2      = !valid_s2 || en3;
	assign in_ready = en2;

	// normalised depth, clipped at one
	assign n_full = prod_s2[dpcm_pkg::PROD_W-1 -: dpcm_pkg::NFULL_W];
	assign n_sat  = (n_full > dpcm_pkg::NFULL_W'(dpcm_pkg::ONE_Q_L)) ?
			dpcm_pkg::N_W'(dpcm_pkg::ONE_Q_L) : n_full[dpcm_pkg::N_W-1:0];
	// times six as two shifts
	assign h6 = (dpcm_pkg::H6_W'(n_sat) << 2) + (dpcm_pkg::H6_W'(n_sat) << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en2) begin
				valid_s2 <= in_valid;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && in_valid) begin
			cls_s2  <= in_data.cls;
			prod_s2 <= dpcm_pkg::PROD_W'(in_data.diff) * dpcm_pkg::PROD_W'(inv_range);
		end
		if (en3 && valid_s2) begin
			hue_s3.cls     <= cls_s2;
			hue_s3.sextant <= h6[dpcm_pkg::H6_W-1:dpcm_pkg::FRAC_BITS];
			hue_s3.fract   <= h6[dpcm_pkg::FRAC_BITS-1:0];
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = hue_s3;

endmodule

// ----- hdl/dpcm_shade.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpcm_shade
// two stages: ramp value from the fraction, then sextant select and byte pack
// ---------------------------------------------------------------------------
module dpcm_shade (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  dpcm_pkg::hue_t        in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           rgba
);

	localparam int F  = dpcm_pkg::FRAC_BITS;
	localparam int PW = 2 * dpcm_pkg::FRAC_BITS;

	logic                           valid_s4;
	dpcm_pkg::pix_class_t           cls_s4;
	logic [dpcm_pkg::SEXT_W-1:0]    sextant_s4;
	logic [F-1:0]                   mid1_s4;
	logic [F-1:0]                   mid2_s4;
	logic                           valid_s5;
	logic [31:0]                    rgba_s5;
	logic                           en4;
	logic                           en5;
	logic [PW-1:0]                  vsf_full;
	logic [F-1:0]                   vsf;
	logic [F-1:0]                   r;
	logic [F-1:0]                   g;
	logic [F-1:0]                   b;
	logic                           no_hue;
	logic [31:0]                    rgba_d;

	function automatic logic [7:0] to_byte(input logic [F-1:0] c);
		logic [F+7:0] c255;
		begin
			c255 = ((F+8)'(c) << 8) - (F+8)'(c);
			return c255[F+7:F];
		end
	endfunction

	assign en5      = !valid_s5 || out_ready;
	assign en4      = !valid_s4 || en5;
	assign in_ready = en4;

	assign vsf_full = PW'(dpcm_pkg::VS_Q) * PW'(in_data.fract);
	assign vsf      = vsf_full[PW-1:F];

	always_comb begin
		no_hue = 1'b0;
		r = '0;
		g = '0;
		b = '0;
		case (sextant_s4)
			dpcm_pkg::SEXT_0: begin r = dpcm_pkg::V_Q; g = mid1_s4; b = dpcm_pkg::M_Q; end
			dpcm_pkg::SEXT_1: begin r = mid2_s4; g = dpcm_pkg::V_Q; b = dpcm_pkg::M_Q; end
			dpcm_pkg::SEXT_2: begin r = dpcm_pkg::M_Q; g = dpcm_pkg::V_Q; b = mid1_s4; end
			dpcm_pkg::SEXT_3: begin r = dpcm_pkg::M_Q; g = mid2_s4; b = dpcm_pkg::V_Q; end
			dpcm_pkg::SEXT_4: begin r = mid1_s4; g = dpcm_pkg::M_Q; b = dpcm_pkg::V_Q; end
			dpcm_pkg::SEXT_5: begin r = dpcm_pkg::V_Q; g = dpcm_pkg::M_Q; b = mid2_s4; end
			default: begin
				// fraction at one spills into a seventh sextant: black
				no_hue = 1'b1;
			end
		endcase

		case (cls_s4)
			dpcm_pkg::CLS_BLACK: rgba_d = dpcm_pkg::RGBA_BLACK;
			dpcm_pkg::CLS_GRAY:  rgba_d = dpcm_pkg::RGBA_GRAY;
			dpcm_pkg::CLS_WHITE: rgba_d = dpcm_pkg::RGBA_WHITE;
			default: begin
				rgba_d = no_hue ? dpcm_pkg::RGBA_BLACK :
					{dpcm_pkg::ALPHA_OPAQUE, to_byte(b), to_byte(g), to_byte(r)};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en4) begin
				valid_s4 <= in_valid;
			end
			if (en5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && in_valid) begin
			cls_s4     <= in_data.cls;
			sextant_s4 <= in_data.sextant;
			mid1_s4    <= dpcm_pkg::M_Q + vsf;
			mid2_s4    <= dpcm_pkg::V_Q - vsf;
		end
		if (en5 && valid_s4) begin
			rgba_s5 <= rgba_d;
		end
	end

	assign out_valid = valid_s5;
	assign rgba      = rgba_s5;

endmodule
